[rtl/xor_checked_frame_receiver_macros.svh]
// Assertion shorthands for the XOR-checked frame receiver.
// Assumes signals named clk and rst in the including module.
`ifndef XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, ignored during reset.
`define XCFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored during reset.
`define XCFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/xcfr_pkg.sv]
// Shared types and fixed field widths for the XOR-checked frame receiver.
// No dependencies.
`default_nettype none

package xcfr_pkg;

  localparam int OCTET_W = 8;
  localparam int POS_W   = 6;
  localparam int TICK_W  = 16;

  typedef logic [OCTET_W-1:0] octet_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [TICK_W-1:0]  tick_t;

  // Input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Configuration register indexes
  localparam logic REG_SYNC    = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam octet_t SYNC_RESET    = 8'hAA;
  localparam tick_t  TIMEOUT_RESET = 16'd50;
  localparam tick_t  TICK_MAX      = 16'hFFFF;

endpackage

`default_nettype wire

[rtl/xor_checked_frame_receiver.sv]
// Top level of the XOR-checked frame receiver: receive control, frame RAM, readout.
// Depends on xcfr_pkg, xcfr_ram and xor_checked_frame_receiver_macros.svh.
//
//   Channel  | Dir | Handshake          | Payload
//   ---------+-----+--------------------+------------------------------------------
//   in       | in  | in_valid/in_ready  | mode, data_byte
//   out      | out | out_valid/out_ready| frame_byte, byte_position, last_of_frame
//   cfg      | in  | cfg_we (no wait)   | cfg_index, cfg_data
//
// One input item per cycle while receiving; bytes and ticks update the counters
// in the cycle of their transfer and each kept byte is written to the frame RAM.
// A good checksum starts a readout of FRAME_BYTES results, one per cycle when the
// sink keeps up; input is held off until the last result is in the output
// register, as the RAM has one read port. Synchronous reset clears counters,
// state and config but not RAM contents. Output stalls hold the readout in place.
`default_nettype none
`include "xor_checked_frame_receiver_macros.svh"

module xor_checked_frame_receiver #(
  parameter int FRAME_BYTES = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  // input items
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           mode,
  input  wire xcfr_pkg::octet_t data_byte,
  // results
  output logic                out_valid,
  input  wire logic           out_ready,
  output xcfr_pkg::octet_t    frame_byte,
  output xcfr_pkg::pos_t      byte_position,
  output logic                last_of_frame,
  // configuration
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire xcfr_pkg::tick_t cfg_data
);

  import xcfr_pkg::*;

  localparam int   AW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int   PTR_W = $clog2(FRAME_BYTES + 1);
  localparam pos_t LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(FRAME_BYTES);

  localparam logic ST_RECV = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Configuration
  octet_t sync_value;
  tick_t  timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value    <= SYNC_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC:    sync_value    <= cfg_data[OCTET_W-1:0];
        REG_TIMEOUT: timeout_ticks <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Receive state
  logic   state, state_next;
  pos_t   fill_count, fill_count_next;
  octet_t running_xor, running_xor_next;
  tick_t  idle_ticks, idle_ticks_next;

  logic   in_xfer;
  logic   ram_we;
  logic   frame_ok;
  tick_t  tick_inc;

  // Readout
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic   rd_pending, rd_pending_next;
  pos_t   pend_pos;
  logic   rd_issue;
  logic   load;
  logic   read_done;
  octet_t rd_data;

  assign in_ready = (state == ST_RECV);
  assign in_xfer  = in_valid && in_ready;
  assign tick_inc = (idle_ticks == TICK_MAX) ? idle_ticks : idle_ticks + 1'b1;

  // Move RAM data into the output register whenever it is free or draining.
  assign load      = rd_pending && (!out_valid || out_ready);
  assign rd_issue  = (state == ST_READ) && (rd_ptr != PTR_END) && (!rd_pending || load);
  assign read_done = (state == ST_READ) && (rd_ptr == PTR_END) && (!rd_pending || load);

  always_comb begin
    state_next       = state;
    fill_count_next  = fill_count;
    running_xor_next = running_xor;
    idle_ticks_next  = idle_ticks;
    rd_ptr_next      = rd_ptr;
    ram_we           = 1'b0;
    frame_ok         = 1'b0;

    if (in_xfer) begin
      if (mode == MODE_TICK) begin
        idle_ticks_next = tick_inc;
        if (fill_count != '0 && tick_inc > timeout_ticks) begin
          fill_count_next  = '0;
          running_xor_next = '0;
        end
      end else begin
        idle_ticks_next = '0;
        if (fill_count == '0 && data_byte != sync_value) begin
          // stray byte outside a frame
        end else if (fill_count != LAST_POS) begin
          ram_we           = 1'b1;
          running_xor_next = running_xor ^ data_byte;
          fill_count_next  = fill_count + 1'b1;
        end else begin
          // checksum byte: keep it in the RAM too when it matches, so readout is uniform
          frame_ok         = (running_xor == data_byte);
          ram_we           = frame_ok;
          fill_count_next  = '0;
          running_xor_next = '0;
          if (frame_ok) begin
            state_next  = ST_READ;
            rd_ptr_next = '0;
          end
        end
      end
    end

    if (rd_issue) begin
      rd_ptr_next = rd_ptr + 1'b1;
    end
    if (read_done) begin
      state_next = ST_RECV;
    end

    if (rd_issue) begin
      rd_pending_next = 1'b1;
    end else if (load) begin
      rd_pending_next = 1'b0;
    end else begin
      rd_pending_next = rd_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RECV;
      fill_count  <= '0;
      running_xor <= '0;
      idle_ticks  <= '0;
      rd_ptr      <= '0;
      rd_pending  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      fill_count  <= fill_count_next;
      running_xor <= running_xor_next;
      idle_ticks  <= idle_ticks_next;
      rd_ptr      <= rd_ptr_next;
      rd_pending  <= rd_pending_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      pend_pos <= POS_W'(rd_ptr);
    end
    if (load) begin
      frame_byte    <= rd_data;
      byte_position <= pend_pos;
      last_of_frame <= (pend_pos == LAST_POS);
    end
  end

  xcfr_ram #(
    .WIDTH (OCTET_W),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[AW-1:0]),
    .wdata (data_byte),
    .re    (rd_issue),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (rd_data)
  );

  // Checks
  `XCFR_ASSERT_NOW(a_recv_no_pending, state == ST_RECV, !rd_pending,
    "read outstanding while receiving")
  `XCFR_ASSERT_NEXT(a_pending_holds, rd_pending && !load, rd_pending && $stable(rd_data),
    "stalled read data lost")
  `XCFR_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= LAST_POS,
    "fill count beyond frame length")
  `XCFR_ASSERT_NEXT(a_good_frame_reads, in_xfer && frame_ok,
    state == ST_READ && fill_count == '0 && rd_ptr == '0,
    "good frame did not start readout")

endmodule

`default_nettype wire

[rtl/xcfr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds until the next read enable. No dependencies.
`default_nettype none

module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[dv/frame_checker.sv]
`timescale 1ns / 100ps
// Frame checker for the XOR-checked frame receiver: mirrors the receive state,
// predicts the readout of each good frame and compares it byte by byte.
// Depends on xcfr_pkg only; watches the ports, drives nothing on the block.
module frame_checker #(
  parameter int FRAME_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             mode,
  input  xcfr_pkg::octet_t data_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  xcfr_pkg::octet_t frame_byte,
  input  xcfr_pkg::pos_t   byte_position,
  input  logic             last_of_frame,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  xcfr_pkg::tick_t  cfg_data,
  output int               mismatches,
  output int               bytes_owed
);
  import xcfr_pkg::*;

  typedef struct packed {
    octet_t value;
    pos_t   pos;
    logic   last;
  } frame_beat_t;

  frame_beat_t bytes_due[$];

  // mirrored receive state and register copies
  octet_t held [FRAME_BYTES];
  pos_t   held_count;
  octet_t held_xor;
  tick_t  ticks_idle;
  octet_t sync_byte;
  tick_t  tick_limit;

  initial begin
    mismatches = 0;
    bytes_owed = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // one accepted input item; queues the frame readout when the checksum holds
  task automatic absorb_item(input logic kind, input octet_t b);
    frame_beat_t beat;
    if (kind == MODE_TICK) begin
      if (ticks_idle != TICK_MAX) ticks_idle++;
      if (held_count != 0 && ticks_idle > tick_limit) begin
        held_count = '0;
        held_xor   = '0;
      end
      return;
    end
    ticks_idle = '0;
    if (held_count == 0 && b != sync_byte) return;
    if (held_count + 1 < FRAME_BYTES) begin
      held[held_count] = b;
      held_xor ^= b;
      held_count++;
      return;
    end
    if (held_xor == b) begin
      for (int k = 0; k < FRAME_BYTES - 1; k++) begin
        beat.value = held[k];
        beat.pos   = pos_t'(k);
        beat.last  = 1'b0;
        bytes_due.push_back(beat);
      end
      beat.value = b;
      beat.pos   = pos_t'(FRAME_BYTES - 1);
      beat.last  = 1'b1;
      bytes_due.push_back(beat);
    end
    held_count = '0;
    held_xor   = '0;
  endtask

  always @(posedge clk) begin : watch
    frame_beat_t want;
    if (rst) begin
      bytes_due.delete();
      held_count = '0;
      held_xor   = '0;
      ticks_idle = '0;
      sync_byte  = SYNC_RESET;
      tick_limit = TIMEOUT_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SYNC) sync_byte = cfg_data[7:0];
        else if (cfg_index == REG_TIMEOUT) tick_limit = cfg_data;
      end
      if (in_valid && in_ready) absorb_item(mode, data_byte);
      if (out_valid && out_ready) begin
        if (bytes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %h at position %0d",
                                  frame_byte, byte_position));
        end else begin
          want = bytes_due.pop_front();
          if (frame_byte !== want.value)
            flag_mismatch($sformatf("frame_byte %h, wanted %h at position %0d",
                                    frame_byte, want.value, want.pos));
          if (byte_position !== want.pos)
            flag_mismatch($sformatf("byte_position %0d, wanted %0d",
                                    byte_position, want.pos));
          if (last_of_frame !== want.last)
            flag_mismatch($sformatf("last_of_frame %b, wanted %b at position %0d",
                                    last_of_frame, want.last, want.pos));
        end
      end
    end
    bytes_owed = bytes_due.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the frame receiver bench: clock, reset, stimulus, register writes and verdict.
// Depends on xcfr_pkg, xor_checked_frame_receiver and frame_checker (dv/frame_checker.sv).
module testbench;
  import xcfr_pkg::*;

  localparam int FRAME_LEN   = 16;
  // cycles without any transfer before the run is abandoned; the longest
  // legitimate quiet spell is the output hold-off plus the settle wait
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 80;

  logic   clk;
  logic   rst           = 1'b1;
  logic   in_valid      = 1'b0;
  logic   in_ready;
  logic   mode          = MODE_BYTE;
  octet_t data_byte     = '0;
  logic   out_valid;
  logic   out_ready     = 1'b0;
  octet_t frame_byte;
  pos_t   byte_position;
  logic   last_of_frame;
  logic   cfg_we        = 1'b0;
  logic   cfg_index     = REG_SYNC;
  tick_t  cfg_data      = '0;

  int mismatches;
  int bytes_owed;

  // stimulus-side view of the registers, used to build frames and tick runs
  octet_t cur_sync;
  tick_t  cur_timeout;

  // percentage of cycles in which each side idles; hold_left is a one-off
  // output hold-off, counted down by the receiver process
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int hold_left     = 0;
  int idle_run      = 0;

  xor_checked_frame_receiver #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .byte_position(byte_position),
    .last_of_frame(last_of_frame),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frame_checker #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .byte_position(byte_position),
    .last_of_frame(last_of_frame),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .bytes_owed   (bytes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result sink. Ready is redrawn every cycle from take_idle_pct, except
  // during a hold-off, when it stays low for the whole count so the block
  // backs up and drops in_ready while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // One input transfer. An idle gap may come first; valid is only lowered
  // in a gap, so back-to-back items keep it high across the edge.
  task automatic send_item(input logic kind, input octet_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= kind;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // tick items carry a random, ignored data byte
  task automatic send_ticks(input int n);
    repeat (n) send_item(MODE_TICK, octet_t'($urandom_range(255)));
  endtask

  // Full frame: sync, FRAME_LEN-2 payload bytes, checksum. A run of
  // gap_ticks ticks goes in just before byte gap_at (0 means none).
  // extremes alternates 00/FF payload; a bad frame gets a corrupted checksum.
  task automatic send_frame(input bit good, input bit extremes,
                            input int gap_at, input int gap_ticks);
    octet_t acc;
    octet_t b;
    acc = cur_sync;
    send_item(MODE_BYTE, cur_sync);
    for (int i = 1; i < FRAME_LEN - 1; i++) begin
      if (i == gap_at) send_ticks(gap_ticks);
      b = extremes ? ((i % 2) ? 8'hFF : 8'h00) : octet_t'($urandom_range(255));
      acc ^= b;
      send_item(MODE_BYTE, b);
    end
    if (gap_at == FRAME_LEN - 1) send_ticks(gap_ticks);
    send_item(MODE_BYTE, good ? acc : acc ^ octet_t'($urandom_range(255, 1)));
  endtask

  // opens a frame and leaves it partial
  task automatic send_stub(input int n);
    send_item(MODE_BYTE, cur_sync);
    repeat (n) send_item(MODE_BYTE, octet_t'($urandom_range(255)));
  endtask

  // Both registers in back-to-back write cycles; only called while idle.
  task automatic program_regs(input octet_t s, input tick_t t);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC;
    cfg_data  <= {8'h00, s};
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= t;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_sync    = s;
    cur_timeout = t;
  endtask

  // Stop offering, let the checker see the last transfer, wait for every
  // predicted byte, then allow for a rejected frame still being worked on
  // (no readout to wait for in that case).
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (FRAME_LEN + 8) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; the rest is bad
  // checksums, stubs (timed out or overrun by the next frame), line noise
  // and bare ticks. Dropped noise bytes are not counted.
  task automatic random_traffic(input int n);
    int sent;
    int pick;
    int k;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        k = ($urandom_range(99) < 30) ? int'($urandom_range(cur_timeout)) : 0;
        if ($urandom_range(99) < 8) k = cur_timeout + 1;   // breaks the frame
        send_frame(1'b1, $urandom_range(99) < 5, $urandom_range(FRAME_LEN - 1, 1), k);
        sent += FRAME_LEN + k;
      end else if (pick < 72) begin
        send_frame(1'b0, 1'b0, 0, 0);
        sent += FRAME_LEN;
      end else if (pick < 82) begin
        k = $urandom_range(FRAME_LEN - 2, 1);
        send_stub(k);
        sent += k + 1;
        if ($urandom_range(1)) begin
          send_ticks(cur_timeout + 1);
          sent += cur_timeout + 1;
        end
      end else if (pick < 92) begin
        repeat ($urandom_range(4, 1)) send_item(MODE_BYTE, octet_t'($urandom_range(255)));
      end else begin
        k = $urandom_range(3, 1);
        send_ticks(k);
        sent += k;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase 1: sender mostly busy, sink mostly stalled.
    send_idle_pct = 12;
    take_idle_pct = 78;
    program_regs(SYNC_RESET, 16'd3);
    // noise at both byte extremes and a tick with no frame open
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_TICK, 8'hFF);
    // 00/FF payload; ticks equal to the timeout mid-frame do not discard it
    send_frame(1'b1, 1'b1, 5, 3);
    // partial frame that times out
    send_stub(2);
    send_ticks(4);
    random_traffic(70);
    settle();

    // Phase 2: the other way round, timeout 1, sync 00.
    send_idle_pct = 78;
    take_idle_pct = 12;
    program_regs(8'h00, 16'd1);
    random_traffic(70);
    settle();

    // Largest timeout: the open frame survives a run of ticks.
    send_idle_pct = 0;
    take_idle_pct = 0;
    program_regs(8'hFF, TICK_MAX);
    send_frame(1'b1, 1'b0, 7, 12);
    settle();

    // Zero timeout: a single tick discards an open frame.
    program_regs(8'h5A, 16'd0);
    send_stub(3);
    send_ticks(1);
    send_frame(1'b1, 1'b0, 0, 0);
    settle();

    // Phase 3: no idling, random settings, with a long output hold-off over
    // a good frame so the readout backs up into the input.
    program_regs(octet_t'($urandom_range(255)), tick_t'($urandom_range(8, 2)));
    hold_left = HOLD_CYCLES;
    send_frame(1'b1, 1'b0, 0, 0);
    random_traffic(75);
    settle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[xor_checked_frame_receiver.f]
+incdir+rtl
rtl/xcfr_pkg.sv
rtl/xcfr_ram.sv
rtl/xor_checked_frame_receiver.sv
dv/frame_checker.sv
dv/testbench.sv
